// ===== src/psc_pkg.sv =====
package psc_pkg;

	// payload widths fixed by the channel format
	localparam int REQ_W    = 2;
	localparam int BAND_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int CUT_W    = 16;
	localparam int MAP_W    = 8;
	localparam int PPM_W    = 20;
	localparam int BCNT_W   = 3;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 20;

	typedef enum logic [REQ_W-1:0] {
		REQ_ACCUM   = 2'd0,
		REQ_CUTS    = 2'd1,
		REQ_CONVERT = 2'd2,
		REQ_CLEAR   = 2'd3
	} psc_req_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_BAND_COUNT = 2'd0,
		CFG_LOW_PPM    = 2'd1,
		CFG_HIGH_PPM   = 2'd2,
		CFG_UNUSED     = 2'd3
	} psc_cfg_idx_t;

	localparam logic KIND_CUTS   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// register reset values
	localparam logic [BCNT_W-1:0] BAND_COUNT_RST = 3'd1;
	localparam logic [PPM_W-1:0]  PPM_RST        = 20'd1000;

	// threshold test: cum*FRAC_ONE + FRAC_BIAS > ppm*total
	localparam int FRAC_ONE  = 1000000;
	localparam int FRAC_BIAS = 100;

	// mapped output codes
	localparam logic [MAP_W-1:0] MAP_ZERO  = 8'd0;
	localparam logic [MAP_W-1:0] MAP_BELOW = 8'd1;
	localparam logic [MAP_W-1:0] MAP_FLOOR = 8'd2;
	localparam logic [MAP_W-1:0] MAP_ABOVE = 8'd254;
	localparam int               MAP_SPAN  = 251;
	localparam int               QUO_W     = 8;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ACC,
		S_TOTAL,
		S_LOW,
		S_HIGH,
		S_REPORT,
		S_CONV,
		S_DIV,
		S_EMIT
	} psc_state_t;

endpackage

// ===== src/psc_if.sv =====
interface psc_req_if;
	import psc_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [BAND_W-1:0]   band;
	logic [SAMPLE_W-1:0] sample;
	modport source(output valid, req_type, band, sample, input ready);
	modport sink(input valid, req_type, band, sample, output ready);
endinterface

interface psc_rsp_if;
	import psc_pkg::*;
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [BAND_W-1:0] band_index;
	logic [CUT_W-1:0]  low_cut;
	logic [CUT_W-1:0]  high_cut;
	logic [MAP_W-1:0]  mapped_value;
	logic              is_last;
	modport source(output valid, result_kind, band_index, low_cut, high_cut, mapped_value,
		is_last, input ready);
	modport sink(input valid, result_kind, band_index, low_cut, high_cut, mapped_value,
		is_last, output ready);
endinterface

interface psc_cfg_if;
	import psc_pkg::*;
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/percentile_stretch_16_to_8.sv =====
// accumulate: histogram read, then write back of the saturated count
// convert: cases without division skip the bit-serial divider, the rest go through it
// compute: per active band, three sweeps of the histogram
//   memory at one bin per cycle (total, upward low cut, downward high cut)
// clear item and reset: a pass of MAX_BANDS * 2^SAMPLE_BITS bins zeroes the histogram
//   memory; reset restores registers and cuts at once, no input beat taken during the pass
module percentile_stretch_16_to_8 #(
	parameter int MAX_BANDS   = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic clk,
	input  logic arst_n,
	psc_cfg_if.sink   cfg,
	psc_req_if.sink   req,
	psc_rsp_if.source rsp
);
	import psc_pkg::*;

	localparam int BINS    = 1 << SAMPLE_BITS;
	localparam int TOP_BIN = BINS - 1;
	localparam int LIM     = (MAX_BANDS < 4) ? MAX_BANDS : 4;
	localparam int DEPTH   = MAX_BANDS * BINS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PROD_W  = COUNT_BITS + PPM_W;
	localparam int CUM_W   = COUNT_BITS + SAMPLE_BITS + PPM_W + 1;
	localparam int NUM_W   = SAMPLE_BITS + QUO_W;

	typedef logic [SAMPLE_BITS-1:0] bin_t;

	// state and configuration
	psc_state_t        state_q, state_d;
	logic [BCNT_W-1:0] band_count_q;
	logic [PPM_W-1:0]  low_ppm_q;
	logic [PPM_W-1:0]  high_ppm_q;
	logic [BCNT_W-1:0] n_act;

	// histogram memory ports
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [COUNT_BITS-1:0] rd_data;

	logic [ADDR_W-1:0] clr_q;
	logic              accept;

	// latched item
	logic [BAND_W-1:0] band_q;
	bin_t              smp_q;

	// sweep pipeline
	logic [BCNT_W-1:0] b_q;
	bin_t              bin_q;
	logic              issue_q;
	logic              v_s1, v_s2;
	bin_t              bin_s1, bin_s2;
	logic [PROD_W-1:0] prod_a_s2, prod_b_s2;
	logic [PPM_W-1:0]  mul_op;
	logic [CUM_W-1:0]  acc_q, rl_q, rh_q;
	logic [CUM_W-1:0]  sum_next, thr;
	logic              hit, pipe_empty, kill;
	bin_t              lo_new_q, hi_new_q;

	// cuts per band
	bin_t lo_cut_q [MAX_BANDS];
	bin_t hi_cut_q [MAX_BANDS];
	bin_t lo_sel, hi_sel;

	// convert path
	logic [MAP_W-1:0]  map_q;
	logic              conv_active, conv_special;
	logic [MAP_W-1:0]  conv_map;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  div_num;
	logic [QUO_W-1:0]  div_quo;

	// output register
	logic              ovalid_q, okind_q, olast_q;
	logic [BAND_W-1:0] oband_q;
	logic [CUT_W-1:0]  olo_q, ohi_q;
	logic [MAP_W-1:0]  omap_q;
	logic              out_free;

	function automatic logic [ADDR_W-1:0] bin_addr(input logic [BCNT_W-1:0] b, input bin_t v);
		return (ADDR_W'(b) << SAMPLE_BITS) | ADDR_W'(v);
	endfunction

	// clamp band count to 1 .. LIM
	always_comb begin
		if (band_count_q == '0) begin
			n_act = BCNT_W'(1);
		end else if (band_count_q > BCNT_W'(LIM)) begin
			n_act = BCNT_W'(LIM);
		end else begin
			n_act = band_count_q;
		end
	end

	// configuration, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= BAND_COUNT_RST;
			low_ppm_q    <= PPM_RST;
			high_ppm_q   <= PPM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BAND_COUNT: band_count_q <= cfg.data[BCNT_W-1:0];
				CFG_LOW_PPM:    low_ppm_q    <= cfg.data[PPM_W-1:0];
				CFG_HIGH_PPM:   high_ppm_q   <= cfg.data[PPM_W-1:0];
				default:        ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !ovalid_q || rsp.ready;

	psc_hist_mem #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(COUNT_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// memory port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = bin_addr(b_q, bin_q);
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = accept && (req.req_type == REQ_ACCUM);
				rd_addr = bin_addr(BCNT_W'(req.band), req.sample[SAMPLE_BITS-1:0]);
			end
			S_ACC: begin
				// saturating increment of the count read last cycle
				wr_en   = 1'b1;
				wr_addr = bin_addr(BCNT_W'(band_q), smp_q);
				wr_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
			end
			S_TOTAL, S_LOW, S_HIGH: begin
				rd_en = issue_q;
			end
			default: ;
		endcase
	end

	// cumulative threshold test on the bin in stage 2
	assign sum_next   = acc_q + CUM_W'(prod_a_s2);
	assign thr        = (state_q == S_LOW) ? rl_q : rh_q;
	assign hit        = v_s2 && ((sum_next + CUM_W'(FRAC_BIAS)) > thr)
		&& (state_q == S_LOW || state_q == S_HIGH);
	assign pipe_empty = !issue_q && !v_s1 && !v_s2;
	assign kill       = hit;
	// total sweep scales by the clip fractions, cut sweeps by one million
	assign mul_op     = (state_q == S_TOTAL) ? low_ppm_q : PPM_W'(FRAC_ONE);

	// cut lookup for the convert band
	always_comb begin
		lo_sel = lo_cut_q[0];
		hi_sel = hi_cut_q[0];
		for (int i = 0; i < MAX_BANDS; i++) begin
			if (int'(band_q) == i) begin
				lo_sel = lo_cut_q[i];
				hi_sel = hi_cut_q[i];
			end
		end
	end

	// mapping cases that need no division
	always_comb begin
		conv_active  = {1'b0, band_q} < n_act;
		conv_special = 1'b1;
		conv_map     = MAP_ZERO;
		if (!conv_active || smp_q == '0) begin
			conv_map = MAP_ZERO;
		end else if (smp_q > hi_sel) begin
			conv_map = MAP_ABOVE;
		end else if (smp_q < lo_sel) begin
			conv_map = MAP_BELOW;
		end else if (hi_sel == lo_sel) begin
			conv_map = MAP_FLOOR;
		end else begin
			conv_special = 1'b0;
		end
	end

	assign div_start = (state_q == S_CONV) && !conv_special;
	assign div_num   = NUM_W'(MAP_SPAN) * NUM_W'(smp_q - lo_sel);

	psc_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (hi_sel - lo_sel),
		.done  (div_done),
		.quo   (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_ACCUM: begin
							if ({1'b0, req.band} < n_act) begin
								state_d = S_ACC;
							end
						end
						REQ_CUTS:    state_d = S_TOTAL;
						REQ_CONVERT: state_d = S_CONV;
						REQ_CLEAR:   state_d = S_CLEAR;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_ACC:   state_d = S_IDLE;
			S_TOTAL: begin
				if (pipe_empty) begin
					state_d = S_LOW;
				end
			end
			S_LOW: begin
				if (hit || pipe_empty) begin
					state_d = S_HIGH;
				end
			end
			S_HIGH: begin
				if (hit || pipe_empty) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					state_d = (b_q + 1'b1 == n_act) ? S_IDLE : S_TOTAL;
				end
			end
			S_CONV:  state_d = conv_special ? S_EMIT : S_DIV;
			S_DIV: begin
				if (div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: clear pointer, sweep issue, pipeline valids, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			b_q      <= '0;
			bin_q    <= '0;
			issue_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			v_s1 <= issue_q && !kill;
			v_s2 <= v_s1 && !kill;
			// a new beat loads the output register, otherwise it empties when taken
			if ((state_q == S_REPORT || state_q == S_EMIT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= (clr_q == ADDR_W'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
				end
				S_IDLE: begin
					if (accept && req.req_type == REQ_CUTS) begin
						b_q     <= '0;
						bin_q   <= bin_t'(1);
						issue_q <= 1'b1;
					end
				end
				S_TOTAL, S_LOW: begin
					if (state_q == S_TOTAL && pipe_empty) begin
						bin_q   <= bin_t'(1);
						issue_q <= 1'b1;
					end else if (state_q == S_LOW && (hit || pipe_empty)) begin
						// high cut walks down from the second-highest bin
						bin_q   <= bin_t'(TOP_BIN - 1);
						issue_q <= 1'b1;
					end else if (issue_q) begin
						bin_q <= bin_q + 1'b1;
						if (bin_q == bin_t'(TOP_BIN)) begin
							issue_q <= 1'b0;
						end
					end
				end
				S_HIGH: begin
					if (hit || pipe_empty) begin
						issue_q <= 1'b0;
					end else if (issue_q) begin
						bin_q <= bin_q - 1'b1;
						if (bin_q == bin_t'(1)) begin
							issue_q <= 1'b0;
						end
					end
				end
				S_REPORT: begin
					if (out_free) begin
						if (b_q + 1'b1 != n_act) begin
							b_q     <= b_q + 1'b1;
							bin_q   <= bin_t'(1);
							issue_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// sweep datapath
	always_ff @(posedge clk) begin
		bin_s1    <= bin_q;
		bin_s2    <= bin_s1;
		prod_a_s2 <= PROD_W'(rd_data) * PROD_W'(mul_op);
		prod_b_s2 <= PROD_W'(rd_data) * PROD_W'(high_ppm_q);
		case (state_q)
			S_IDLE, S_REPORT: begin
				rl_q <= '0;
				rh_q <= '0;
			end
			S_TOTAL: begin
				if (v_s2) begin
					rl_q <= rl_q + CUM_W'(prod_a_s2);
					rh_q <= rh_q + CUM_W'(prod_b_s2);
				end
				acc_q    <= '0;
				lo_new_q <= bin_t'(1);
				hi_new_q <= bin_t'(TOP_BIN);
			end
			S_LOW: begin
				if (hit || pipe_empty) begin
					acc_q <= '0;
				end else if (v_s2) begin
					acc_q <= sum_next;
				end
				if (hit) begin
					lo_new_q <= bin_s2;
				end
			end
			S_HIGH: begin
				if (v_s2) begin
					acc_q <= sum_next;
				end
				if (hit) begin
					hi_new_q <= bin_s2;
				end
			end
			default: ;
		endcase
	end

	// latched item and mapped value
	always_ff @(posedge clk) begin
		if (accept) begin
			band_q <= req.band;
			smp_q  <= req.sample[SAMPLE_BITS-1:0];
		end
		if (state_q == S_CONV && conv_special) begin
			map_q <= conv_map;
		end
		if (state_q == S_DIV && div_done) begin
			map_q <= div_quo + MAP_FLOOR;
		end
	end

	// stored cuts, kept across clear items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BANDS; i++) begin
				lo_cut_q[i] <= bin_t'(1);
				hi_cut_q[i] <= bin_t'(TOP_BIN);
			end
		end else if (state_q == S_REPORT && out_free) begin
			for (int i = 0; i < MAX_BANDS; i++) begin
				if (int'(b_q) == i) begin
					lo_cut_q[i] <= lo_new_q;
					hi_cut_q[i] <= hi_new_q;
				end
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == S_REPORT && out_free) begin
			okind_q <= KIND_CUTS;
			oband_q <= b_q[BAND_W-1:0];
			olo_q   <= CUT_W'(lo_new_q);
			ohi_q   <= CUT_W'(hi_new_q);
			omap_q  <= MAP_ZERO;
			olast_q <= (b_q + 1'b1 == n_act);
		end else if (state_q == S_EMIT && out_free) begin
			okind_q <= KIND_SAMPLE;
			oband_q <= band_q;
			olo_q   <= '0;
			ohi_q   <= '0;
			omap_q  <= map_q;
			olast_q <= 1'b1;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.result_kind  = okind_q;
	assign rsp.band_index   = oband_q;
	assign rsp.low_cut      = olo_q;
	assign rsp.high_cut     = ohi_q;
	assign rsp.mapped_value = omap_q;
	assign rsp.is_last      = olast_q;
endmodule

// ===== src/psc_hist_mem.sv =====
module psc_hist_mem #(
	parameter int DEPTH  = 262144,
	parameter int ADDR_W = 18,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== src/psc_div.sv =====
module psc_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SAMPLE_BITS+psc_pkg::QUO_W-1:0] num,
	input  logic [SAMPLE_BITS-1:0]        den,
	output logic                          done,
	output logic [psc_pkg::QUO_W-1:0]     quo
);
	import psc_pkg::*;

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [QUO_W-1:0]       shf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   diff;

	// quotient stays below 2^QUO_W, so the top part of num is already below den
	assign trial = {rem_q, shf_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[SAMPLE_BITS+QUO_W-1:QUO_W];
			shf_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[SAMPLE_BITS]) begin
				rem_q <= diff[SAMPLE_BITS-1:0];
				shf_q <= {shf_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[SAMPLE_BITS-1:0];
				shf_q <= {shf_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = shf_q;
endmodule
